### rtl/hbtm_pkg.sv
// hbtm_pkg: shared types and constants of the heartbeat timeout monitor
`default_nettype none

package hbtm_pkg;

  // default sizing
  localparam int unsigned ChannelsDef   = 8;
  localparam int unsigned CreditBitsDef = 4;

  // field widths
  localparam int unsigned ChanW   = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 8;
  localparam int unsigned AuxW    = 32;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned WinW    = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // register reset values
  localparam logic [CfgW-1:0]  LimitsRst = 32'h0664_2222;
  localparam logic [MaskW-1:0] MaskRst   = 8'd0;
  localparam logic [WinW-1:0]  WindowRst = 16'd999;

  // rounding divider: (2*elapsed + n) / (2*n)
  localparam int unsigned DivNumW  = TimeW + 2;
  localparam int unsigned DivDenW  = FrameW + 1;
  localparam int unsigned DivSteps = DivNumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CREDIT_LIMITS = 2'd0,
    REG_AVERAGE_MASK  = 2'd1,
    REG_WINDOW_MS     = 2'd2
  } reg_idx_e;

  // operation codes
  typedef enum logic {
    OP_FEED = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec_feed;
    logic exec_poll;
    logic div_start;
    logic div_write;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ch_valid;
    logic is_poll;
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/hbtm_div.sv
// hbtm_div: radix-2 restoring divider for the averaged interval
`default_nettype none

module hbtm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [hbtm_pkg::DivNumW-1:0] dividend_i,
  input  wire logic [hbtm_pkg::DivDenW-1:0] divisor_i,
  output logic                              done_o,
  output logic [hbtm_pkg::TimeW-1:0]        quotient_o
);

  localparam int unsigned NW = hbtm_pkg::DivNumW;
  localparam int unsigned DW = hbtm_pkg::DivDenW;
  localparam int unsigned CW = hbtm_pkg::DivCntW;

  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(hbtm_pkg::DivSteps);
    end else if (cnt_q != '0) begin
      if (!diff[DW+1]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[hbtm_pkg::TimeW-1:0];

endmodule

`default_nettype wire

### rtl/hbtm_dp.sv
// hbtm_dp: configuration, channel records, divider and result registers
`default_nettype none

module hbtm_dp #(
  parameter int unsigned CHANNELS    = hbtm_pkg::ChannelsDef,
  parameter int unsigned CREDIT_BITS = hbtm_pkg::CreditBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hbtm_pkg::dp_cmd_t                   cmd_i,
  output hbtm_pkg::dp_sts_t                        sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [hbtm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [hbtm_pkg::CfgW-1:0]           cfg_wdata_i,
  input  wire logic                                operation_i,
  input  wire logic [hbtm_pkg::ChanW-1:0]          channel_i,
  input  wire logic [hbtm_pkg::TimeW-1:0]          time_now_ms_i,
  input  wire logic [hbtm_pkg::StatusW-1:0]        status_code_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0]    aux_a_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0]    aux_b_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0]    aux_c_i,
  output logic                                     result_valid_o,
  output logic [hbtm_pkg::ChanW-1:0]               out_channel_o,
  output logic [hbtm_pkg::StatusW-1:0]             out_status_o,
  output logic [hbtm_pkg::TimeW-1:0]               interval_ms_o,
  output logic signed [hbtm_pkg::AuxW-1:0]         out_aux_a_o,
  output logic signed [hbtm_pkg::AuxW-1:0]         out_aux_b_o,
  output logic signed [hbtm_pkg::AuxW-1:0]         out_aux_c_o,
  output logic                                     timed_out_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TW   = hbtm_pkg::TimeW;
  localparam int unsigned FW   = hbtm_pkg::FrameW;
  localparam int unsigned AW   = hbtm_pkg::AuxW;

  // configuration registers
  logic [hbtm_pkg::CfgW-1:0]  limits_q;
  logic [hbtm_pkg::MaskW-1:0] mask_q;
  logic [hbtm_pkg::WinW-1:0]  window_q;

  // latched input word
  logic                         op_q;
  logic [hbtm_pkg::ChanW-1:0]   ch_q;
  logic [TW-1:0]                now_q;
  logic [hbtm_pkg::StatusW-1:0] status_q;
  logic signed [AW-1:0]         aux_a_q, aux_b_q, aux_c_q;

  // channel records
  logic [CREDIT_BITS-1:0]       credit_q   [CHANNELS];
  logic [TW-1:0]                last_q     [CHANNELS];
  logic [FW-1:0]                frames_q   [CHANNELS];
  logic [hbtm_pkg::StatusW-1:0] stat_q     [CHANNELS];
  logic [TW-1:0]                interval_q [CHANNELS];
  logic signed [AW-1:0]         rec_a_q    [CHANNELS];
  logic signed [AW-1:0]         rec_b_q    [CHANNELS];
  logic signed [AW-1:0]         rec_c_q    [CHANNELS];

  logic [CH_W-1:0]              ch_idx;
  logic [TW-1:0]                elapsed;
  logic [FW-1:0]                frames_cur, frames_inc;
  logic                         avg_mode;
  logic                         need_div;
  logic [31:0]                  lim_sh;
  logic [CREDIT_BITS-1:0]       limit;
  logic [CREDIT_BITS-1:0]       credit_dec;
  logic [hbtm_pkg::DivNumW-1:0] dividend;
  logic [hbtm_pkg::DivDenW-1:0] divisor;
  logic                         div_done;
  logic [TW-1:0]                quotient;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= hbtm_pkg::LimitsRst;
      mask_q   <= hbtm_pkg::MaskRst;
      window_q <= hbtm_pkg::WindowRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hbtm_pkg::REG_CREDIT_LIMITS: limits_q <= cfg_wdata_i;
        hbtm_pkg::REG_AVERAGE_MASK:  mask_q   <= cfg_wdata_i[hbtm_pkg::MaskW-1:0];
        hbtm_pkg::REG_WINDOW_MS:     window_q <= cfg_wdata_i[hbtm_pkg::WinW-1:0];
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      ch_q     <= channel_i;
      now_q    <= time_now_ms_i;
      status_q <= status_code_i;
      aux_a_q  <= aux_a_i;
      aux_b_q  <= aux_b_i;
      aux_c_q  <= aux_c_i;
    end
  end

  // per-item arithmetic on the addressed record
  always_comb begin
    ch_idx     = CH_W'(ch_q);
    elapsed    = now_q - last_q[ch_idx];
    frames_cur = frames_q[ch_idx];
    frames_inc = (frames_cur == {FW{1'b1}}) ? frames_cur : frames_cur + 1'b1;
    avg_mode   = mask_q[ch_q];
    need_div   = avg_mode && (elapsed > TW'(window_q));
    lim_sh     = 32'(ch_q) * 32'(CREDIT_BITS);
    limit      = (lim_sh >= 32'd32) ? '0 : CREDIT_BITS'(limits_q >> lim_sh);
    credit_dec = (credit_q[ch_idx] == '0) ? '0 : credit_q[ch_idx] - 1'b1;
    dividend   = {1'b0, elapsed, 1'b0} + hbtm_pkg::DivNumW'(frames_inc);
    divisor    = {frames_inc, 1'b0};
  end

  assign sts_o.ch_valid = (32'(ch_q) < 32'(CHANNELS));
  assign sts_o.is_poll  = (op_q == hbtm_pkg::OP_POLL);
  assign sts_o.need_div = need_div;
  assign sts_o.div_done = div_done;

  // divider for the window average
  hbtm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // record updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        credit_q[i]   <= '0;
        last_q[i]     <= '0;
        frames_q[i]   <= '0;
        stat_q[i]     <= '0;
        interval_q[i] <= '0;
        rec_a_q[i]    <= '0;
        rec_b_q[i]    <= '0;
        rec_c_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.exec_feed) begin
        stat_q[ch_idx]   <= status_q;
        rec_a_q[ch_idx]  <= aux_a_q;
        rec_b_q[ch_idx]  <= aux_b_q;
        rec_c_q[ch_idx]  <= aux_c_q;
        credit_q[ch_idx] <= limit;
        if (!avg_mode) begin
          interval_q[ch_idx] <= elapsed;
          last_q[ch_idx]     <= now_q;
        end else if (need_div) begin
          last_q[ch_idx]   <= now_q;
          frames_q[ch_idx] <= '0;
        end else begin
          frames_q[ch_idx] <= frames_inc;
        end
      end
      if (cmd_i.exec_poll) begin
        credit_q[ch_idx] <= credit_dec;
      end
      if (cmd_i.div_write) begin
        interval_q[ch_idx] <= quotient;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.exec_poll;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_poll) begin
      out_channel_o <= ch_q;
      out_status_o  <= stat_q[ch_idx];
      interval_ms_o <= interval_q[ch_idx];
      out_aux_a_o   <= rec_a_q[ch_idx];
      out_aux_b_o   <= rec_b_q[ch_idx];
      out_aux_c_o   <= rec_c_q[ch_idx];
      timed_out_o   <= (credit_dec == '0);
    end
  end

endmodule

`default_nettype wire

### rtl/hbtm_ctrl.sv
// hbtm_ctrl: item sequencing state machine
`default_nettype none

module hbtm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire hbtm_pkg::dp_sts_t sts_i,
  output hbtm_pkg::dp_cmd_t      cmd_o
);

  hbtm_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbtm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      hbtm_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = hbtm_pkg::ST_EXEC;
        end
      end
      hbtm_pkg::ST_EXEC: begin
        state_d = hbtm_pkg::ST_IDLE;
        if (sts_i.ch_valid) begin
          if (sts_i.is_poll) begin
            cmd_o.exec_poll = 1'b1;
          end else begin
            cmd_o.exec_feed = 1'b1;
            if (sts_i.need_div) begin
              cmd_o.div_start = 1'b1;
              state_d         = hbtm_pkg::ST_DIV;
            end
          end
        end
      end
      hbtm_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_write = 1'b1;
          state_d         = hbtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hbtm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/heartbeat_timeout_monitor_core.sv
// heartbeat_timeout_monitor_core: top level of the heartbeat timeout monitor
//
//   channel   direction  handshake                 payload
//   command   in         start / busy              operation, channel, time, status, aux a..c
//   result    out        result_valid_o (strobe)   channel, status, interval, aux a..c, timeout
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A poll or a plain feed passes through the EXEC state and returns to idle for the next word.
// A feed that closes an averaging window also runs the radix-2 divider in the DIV
// state, one quotient bit per cycle over 34 bits, then writes the quotient back.
// The poll result appears in the cycle after the item is processed, for one cycle.
// Reset clears all channel records; the block is ready right after reset.
// The receiver cannot stall results.
`default_nettype none

module heartbeat_timeout_monitor_core #(
  parameter int unsigned CHANNELS    = hbtm_pkg::ChannelsDef,
  parameter int unsigned CREDIT_BITS = hbtm_pkg::CreditBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cfg_we_i,
  input  wire logic [hbtm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [hbtm_pkg::CfgW-1:0]        cfg_wdata_i,
  input  wire logic                             operation_i,
  input  wire logic [hbtm_pkg::ChanW-1:0]       channel_i,
  input  wire logic [hbtm_pkg::TimeW-1:0]       time_now_ms_i,
  input  wire logic [hbtm_pkg::StatusW-1:0]     status_code_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0] aux_a_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0] aux_b_i,
  input  wire logic signed [hbtm_pkg::AuxW-1:0] aux_c_i,
  output logic                                  result_valid_o,
  output logic [hbtm_pkg::ChanW-1:0]            out_channel_o,
  output logic [hbtm_pkg::StatusW-1:0]          out_status_o,
  output logic [hbtm_pkg::TimeW-1:0]            interval_ms_o,
  output logic signed [hbtm_pkg::AuxW-1:0]      out_aux_a_o,
  output logic signed [hbtm_pkg::AuxW-1:0]      out_aux_b_o,
  output logic signed [hbtm_pkg::AuxW-1:0]      out_aux_c_o,
  output logic                                  timed_out_o
);

  hbtm_pkg::dp_cmd_t cmd;
  hbtm_pkg::dp_sts_t sts;

  // sequencing
  hbtm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // records and arithmetic
  hbtm_dp #(
    .CHANNELS    (CHANNELS),
    .CREDIT_BITS (CREDIT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .channel_i      (channel_i),
    .time_now_ms_i  (time_now_ms_i),
    .status_code_i  (status_code_i),
    .aux_a_i        (aux_a_i),
    .aux_b_i        (aux_b_i),
    .aux_c_i        (aux_c_i),
    .result_valid_o (result_valid_o),
    .out_channel_o  (out_channel_o),
    .out_status_o   (out_status_o),
    .interval_ms_o  (interval_ms_o),
    .out_aux_a_o    (out_aux_a_o),
    .out_aux_b_o    (out_aux_b_o),
    .out_aux_c_o    (out_aux_c_o),
    .timed_out_o    (timed_out_o)
  );

endmodule

`default_nettype wire
